// ----- src/assert_macros.svh -----
// Assertion macros shared by the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TQ_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- src/tq_pkg.sv -----
// Types, codes and sizing constants of the timer queue.
`timescale 1ns / 1ps
package tq_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CMDQ_DEPTH  = 2;
  localparam int RESQ_DEPTH  = 4;

  localparam int TIME_W  = 48;
  localparam int IVAL_W  = 32;
  localparam int HANDLE_W = 16;

  localparam logic [1:0] FUNC_ADD_ONE = 2'd0;
  localparam logic [1:0] FUNC_ADD_PER = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_FIRED   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [1:0] PASS_ONE = 2'd0;
  localparam logic [1:0] PASS_PER = 2'd1;
  localparam logic [1:0] PASS_SUM = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] handle_id;
    logic [IVAL_W-1:0]   interval_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                status;
    logic [HANDLE_W-1:0] fired_handle;
    logic                fired_periodic;
    logic                next_valid;
    logic [TIME_W-1:0]   next_deadline;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic                is_tick;
    logic                periodic;
    logic [HANDLE_W-1:0] handle;
    logic [IVAL_W-1:0]   interval;
  } cmd_t;

endpackage

// ----- src/tq_fifo.sv -----
// Small register queue used between the front, the engine and the result port.
`timescale 1ns / 1ps
module tq_fifo #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  T              q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/tq_front.sv -----
// Front end: takes requests, clamps the interval, drops unknown codes and queues commands.
`timescale 1ns / 1ps
module tq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tq_pkg::in_item_t in_item,
  output logic             full,
  input  logic             cmd_pop,
  output tq_pkg::cmd_t     cmd,
  output logic             cmd_empty
);

  tq_pkg::cmd_t cls;
  logic         known;

  // An interval of zero behaves as one millisecond.
  always_comb begin
    cls.is_tick  = (in_item.func == tq_pkg::FUNC_TICK);
    cls.periodic = (in_item.func == tq_pkg::FUNC_ADD_PER);
    cls.handle   = in_item.handle_id;
    cls.interval = (in_item.interval_ms == '0) ? tq_pkg::IVAL_W'(1) : in_item.interval_ms;
    known        = (in_item.func == tq_pkg::FUNC_ADD_ONE) ||
                   (in_item.func == tq_pkg::FUNC_ADD_PER) ||
                   (in_item.func == tq_pkg::FUNC_TICK);
  end

  tq_fifo #(
    .T     (tq_pkg::cmd_t),
    .DEPTH (tq_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && known),
    .wr_data (cls),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

endmodule

// ----- src/tq_engine.sv -----
// Back end: timer table, slot allocation, expiry scans and result generation.
`timescale 1ns / 1ps
module tq_engine #(
  parameter int ENTRIES = tq_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  tq_pkg::cmd_t      cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output tq_pkg::out_item_t res
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam int TW = tq_pkg::TIME_W;
  localparam int VW = tq_pkg::IVAL_W;
  localparam int HW = tq_pkg::HANDLE_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ADD    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [TW-1:0]      now_r, now_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] fired_r, fired_nxt;
  logic [1:0]         pass_r, pass_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               iss_r, iss_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               cmp_last_r, cmp_last_nxt;
  logic               found_r, found_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [TW-1:0]      best_dl_r, best_dl_nxt;
  logic [HW-1:0]      best_hd_r, best_hd_nxt;
  logic [VW-1:0]      best_iv_r, best_iv_nxt;
  tq_pkg::cmd_t       cur_r, cur_nxt;

  logic [TW-1:0] mem_dl [ENTRIES];
  logic [VW-1:0] mem_iv [ENTRIES];
  logic [HW-1:0] mem_hd [ENTRIES];
  logic          mem_per [ENTRIES];
  logic [TW-1:0] rd_dl_r;
  logic [VW-1:0] rd_iv_r;
  logic [HW-1:0] rd_hd_r;
  logic          rd_per_r;

  logic          wr_add, wr_resched, cand;
  logic [TW-1:0] add_dl, resched_dl;

  assign add_dl     = now_r + TW'(cur_r.interval);
  assign resched_dl = now_r + TW'(best_iv_r);

  // An entry takes part in a pass if it is live and, for the firing passes, of the right
  // kind, expired and not yet fired on this tick. Ties keep the lower slot.
  always_comb begin
    cand = cmp_vld_r && valid_r[cmp_idx_r] &&
           ((pass_r == tq_pkg::PASS_SUM) ||
            ((rd_per_r == (pass_r == tq_pkg::PASS_PER)) && !fired_r[cmp_idx_r] &&
             (rd_dl_r <= now_r))) &&
           (!found_r || (rd_dl_r < best_dl_r));
  end

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    valid_nxt    = valid_r;
    fired_nxt    = fired_r;
    pass_nxt     = pass_r;
    idx_nxt      = idx_r;
    iss_nxt      = iss_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_last_nxt = 1'b0;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_dl_nxt  = best_dl_r;
    best_hd_nxt  = best_hd_r;
    best_iv_nxt  = best_iv_r;
    cur_nxt      = cur_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    wr_add       = 1'b0;
    wr_resched   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          idx_nxt = '0;
          if (cmd.is_tick) begin
            now_nxt   = now_r + TW'(1);
            pass_nxt  = tq_pkg::PASS_ONE;
            fired_nxt = '0;
            iss_nxt   = 1'b1;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (!valid_r[idx_r]) begin
          if (!res_full) begin
            wr_add          = 1'b1;
            valid_nxt[idx_r] = 1'b1;
            res_push        = 1'b1;
            res.kind        = tq_pkg::KIND_ACK;
            res.status      = tq_pkg::STATUS_OK;
            res.last        = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else if (idx_r == LAST_IDX) begin
          if (!res_full) begin
            res_push   = 1'b1;
            res.kind   = tq_pkg::KIND_ACK;
            res.status = tq_pkg::STATUS_FULL;
            res.last   = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_SCAN: begin
        if (iss_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = idx_r;
          cmp_last_nxt = (idx_r == LAST_IDX);
          iss_nxt      = (idx_r != LAST_IDX);
          idx_nxt      = idx_r + IW'(1);
        end
        if (cand) begin
          found_nxt    = 1'b1;
          best_idx_nxt = cmp_idx_r;
          best_dl_nxt  = rd_dl_r;
          best_hd_nxt  = rd_hd_r;
          best_iv_nxt  = rd_iv_r;
        end
        if (cmp_vld_r && cmp_last_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!res_full) begin
          idx_nxt   = '0;
          iss_nxt   = 1'b1;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
          if (pass_r == tq_pkg::PASS_SUM) begin
            res_push          = 1'b1;
            res.kind          = tq_pkg::KIND_SUMMARY;
            res.next_valid    = found_r;
            res.next_deadline = found_r ? best_dl_r : '0;
            res.last          = 1'b1;
            state_nxt         = ST_IDLE;
          end else if (found_r) begin
            res_push               = 1'b1;
            res.kind               = tq_pkg::KIND_FIRED;
            res.fired_handle       = best_hd_r;
            res.fired_periodic     = (pass_r == tq_pkg::PASS_PER);
            fired_nxt[best_idx_r]  = 1'b1;
            if (pass_r == tq_pkg::PASS_ONE) begin
              valid_nxt[best_idx_r] = 1'b0;
            end else begin
              wr_resched = 1'b1;
            end
          end else begin
            pass_nxt = (pass_r == tq_pkg::PASS_ONE) ? tq_pkg::PASS_PER : tq_pkg::PASS_SUM;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      now_r      <= '0;
      valid_r    <= '0;
      fired_r    <= '0;
      pass_r     <= tq_pkg::PASS_ONE;
      idx_r      <= '0;
      iss_r      <= 1'b0;
      cmp_vld_r  <= 1'b0;
      cmp_last_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      now_r      <= now_nxt;
      valid_r    <= valid_nxt;
      fired_r    <= fired_nxt;
      pass_r     <= pass_nxt;
      idx_r      <= idx_nxt;
      iss_r      <= iss_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      cmp_last_r <= cmp_last_nxt;
      found_r    <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    best_hd_r  <= best_hd_nxt;
    best_iv_r  <= best_iv_nxt;
    cur_r      <= cur_nxt;
  end

  // Table storage: one write port per array, registered read at the scan index.
  always_ff @(posedge clk) begin
    if (wr_add) begin
      mem_dl[idx_r]  <= add_dl;
      mem_iv[idx_r]  <= cur_r.interval;
      mem_hd[idx_r]  <= cur_r.handle;
      mem_per[idx_r] <= cur_r.periodic;
    end else if (wr_resched) begin
      mem_dl[best_idx_r] <= resched_dl;
    end
    rd_dl_r  <= mem_dl[idx_r];
    rd_iv_r  <= mem_iv[idx_r];
    rd_hd_r  <= mem_hd[idx_r];
    rd_per_r <= mem_per[idx_r];
  end

endmodule

// ----- src/oneshot_periodic_timer_queue.sv -----
// Top level of the one-shot and periodic timer queue.
//
//   channel   direction  handshake            payload
//   request   in         push / full          in_item  (func, handle_id, interval_ms)
//   result    out        empty / pop          out_item (kind ... last)
//
// An add request walks the valid bits in the engine one slot per cycle until it finds a free
// slot or reaches the last slot. A tick walks the table once for every timer it fires, plus
// one empty walk to close each of the one-shot and periodic passes and one walk for the
// summary, all through the single read port of the table memory.
// Reset is synchronous and active low; it empties both queues, clears the clock and all
// valid bits. A full result queue stalls the engine where it would push a result, without
// losing any state, while the command queue goes on taking requests until it is full
// itself.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oneshot_periodic_timer_queue #(
  parameter int ENTRIES = tq_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  tq_pkg::in_item_t  in_item,
  output logic              empty,
  input  logic              pop,
  output tq_pkg::out_item_t out_item
);

  // Commands waiting between the front end and the engine.
  tq_pkg::cmd_t cmd;
  logic         cmd_empty;
  logic         cmd_pop;

  // Results on their way from the engine to the output queue.
  tq_pkg::out_item_t res;
  logic              res_push;
  logic              res_full;

  // The front end classifies each request and drops unknown function codes.
  tq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // The engine owns the timer table and the millisecond clock.
  tq_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // The result queue decouples the engine from a slow consumer.
  tq_fifo #(
    .T     (tq_pkg::out_item_t),
    .DEPTH (tq_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

  // The engine must never offer a result that the output queue cannot take.
  `TQ_ASSERT(a_no_push_when_full, clk, rst_n, res_push |-> !res_full, "result lost")
  // The engine must only take a command that is actually waiting.
  `TQ_ASSERT(a_pop_only_waiting, clk, rst_n, cmd_pop |-> !cmd_empty, "command underrun")
  // After reset no stale result may be shown.
  `TQ_ASSERT_RST(a_empty_after_reset, clk, !rst_n |=> empty, "result queue not empty")

endmodule
